/* hdl/sijb_pkg.sv */
package sijb_pkg;

    localparam int SLOT_COUNT_DEF   = 16;
    localparam int PACKET_BYTES_DEF = 50;
    localparam int SEQ_BITS         = 16;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_DATA = 2'd1;
    localparam logic [1:0] ST_REJECT  = 2'd2;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] status;
        logic       last;
    } t_result;

endpackage

/* hdl/sequence_indexed_jitter_buffer_unit.sv */
// Push byte: stored in staging, and a final byte queues a status result. A committed packet then
// stalls the input while it reduces its sequence number to a slot by reciprocal multiplication
// (quotient, then remainder, then slot mark) and then copies staging into the slot memory.
// Pop: the slot's bytes are read out one per cycle while the output is not stalled, and the
// input stays stalled until every byte has been read from the slot. An empty pop answers NO_DATA.
// Reset clears the control state and valid marks and sets the cursor to SLOT_COUNT / 2.
module sequence_indexed_jitter_buffer_unit #(
    parameter int SLOT_COUNT   = sijb_pkg::SLOT_COUNT_DEF,
    parameter int PACKET_BYTES = sijb_pkg::PACKET_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_opcode,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_status,
    output logic       o_last_result
);
    import sijb_pkg::*;

    localparam int SW = $clog2(SLOT_COUNT);
    localparam int IW = $clog2(PACKET_BYTES);
    localparam int CW = $clog2(PACKET_BYTES + 2);
    localparam int XW = $clog2(PACKET_BYTES + 1);
    localparam int AW = $clog2(SLOT_COUNT * PACKET_BYTES);

    localparam int     SHIFT = SEQ_BITS + SW;
    localparam int     MW    = SEQ_BITS + 1;
    localparam int     PW    = SEQ_BITS + MW;
    localparam int     QW    = PW - SHIFT;
    localparam longint RECIP = ((longint'(1) << SHIFT) + longint'(SLOT_COUNT) - 1)
                             / longint'(SLOT_COUNT);

    typedef enum logic [1:0] {S_IDLE, S_MOD, S_COPY, S_POP} t_state;

    t_state                r_state;
    logic [CW-1:0]         r_count;
    logic [SEQ_BITS-1:0]   r_seq;
    logic [1:0]            r_phase;
    logic [QW-1:0]         r_quot;
    logic [SW-1:0]         r_rem;
    logic [XW-1:0]         r_idx;
    logic                  r_pend;
    logic                  r_plast;
    logic [AW-1:0]         r_addr;
    logic [SLOT_COUNT-1:0] r_valid;
    logic [SW-1:0]         r_cursor;
    t_result               r_q [2];
    logic                  r_qh;
    logic [1:0]            r_qcnt;
    logic [7:0]            r_stg_rd;
    logic [7:0]            r_slot_rd;

    logic [7:0] stg_mem  [PACKET_BYTES];
    logic [7:0] slot_mem [SLOT_COUNT * PACKET_BYTES];

    logic                take;
    logic                deq;
    logic                is_push;
    logic                stg_we;
    logic [CW-1:0]       push_count;
    logic                cur_valid;
    logic                credit;
    logic                issue;
    logic                enq_imm;
    logic                enq_mem;
    t_result             enq_data;
    logic [PW-1:0]       seq_prod;
    logic [SEQ_BITS-1:0] seq_rem;
    logic [SW-1:0]       n_cursor;

    assign o_stall  = !(r_state == S_IDLE && r_qcnt != 2'd2);
    assign take     = i_valid && !o_stall;
    assign o_valid  = (r_qcnt != 2'd0);
    assign deq      = o_valid && !i_stall;
    assign o_out_byte    = r_q[r_qh].data;
    assign o_status      = r_q[r_qh].status;
    assign o_last_result = r_q[r_qh].last;

    assign is_push    = (i_opcode == OP_PUSH);
    assign stg_we     = take && is_push && (r_count < CW'(PACKET_BYTES));
    assign push_count = (r_count < CW'(PACKET_BYTES)) ? r_count + 1'b1
                                                      : CW'(PACKET_BYTES + 1);
    assign cur_valid  = r_valid[r_cursor];
    assign n_cursor   = (r_cursor == SW'(SLOT_COUNT - 1)) ? '0 : r_cursor + 1'b1;

    assign credit = ({1'b0, r_qcnt} + 3'(r_pend)) < (3'd2 + 3'(deq));
    assign issue  = (r_idx < XW'(PACKET_BYTES)) &&
                    ((r_state == S_COPY) || (r_state == S_POP && credit));

    assign seq_prod = {{MW{1'b0}}, r_seq} * PW'(RECIP);
    assign seq_rem  = r_seq - SEQ_BITS'(r_quot * SLOT_COUNT);

    assign enq_imm = take && ((is_push && i_last_byte) || (!is_push && !cur_valid));
    assign enq_mem = (r_state == S_POP) && r_pend;

    always_comb begin
        if (enq_mem) begin
            enq_data = '{data: r_slot_rd, status: ST_OK, last: r_plast};
        end else if (is_push) begin
            enq_data = '{data: 8'd0,
                         status: (push_count == CW'(PACKET_BYTES)) ? ST_OK : ST_REJECT,
                         last: 1'b1};
        end else begin
            enq_data = '{data: 8'd0, status: ST_NO_DATA, last: 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_we) begin
            stg_mem[r_count[IW-1:0]] <= i_data_byte;
        end
        if (r_state == S_COPY && issue) begin
            r_stg_rd <= stg_mem[r_idx[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_COPY && r_pend) begin
            slot_mem[r_addr] <= r_stg_rd;
        end
        if (r_state == S_POP && issue) begin
            r_slot_rd <= slot_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_idx    <= '0;
            r_valid  <= '0;
            r_cursor <= SW'(SLOT_COUNT / 2);
            r_qh     <= 1'b0;
            r_qcnt   <= 2'd0;
        end else begin
            if (enq_imm || enq_mem) begin
                r_q[r_qh ^ r_qcnt[0]] <= enq_data;
            end
            if (deq) begin
                r_qh <= ~r_qh;
            end
            r_qcnt <= r_qcnt + 2'(enq_imm || enq_mem) - 2'(deq);

            case (r_state)
                S_IDLE: begin
                    if (take && is_push) begin
                        if (stg_we && r_count == CW'(2)) begin
                            r_seq[SEQ_BITS-1:8] <= i_data_byte;
                        end
                        if (stg_we && r_count == CW'(3)) begin
                            r_seq[7:0] <= i_data_byte;
                        end
                        r_count <= i_last_byte ? '0 : push_count;
                        if (i_last_byte && push_count == CW'(PACKET_BYTES)) begin
                            r_phase <= 2'd0;
                            r_state <= S_MOD;
                        end
                    end else if (take) begin
                        r_cursor <= n_cursor;
                        if (cur_valid) begin
                            r_valid[r_cursor] <= 1'b0;
                            r_addr  <= AW'(r_cursor * PACKET_BYTES);
                            r_idx   <= '0;
                            r_pend  <= 1'b0;
                            r_state <= S_POP;
                        end
                    end
                end
                S_MOD: begin
                    r_phase <= r_phase + 1'b1;
                    if (r_phase == 2'd0) begin
                        r_quot <= seq_prod[PW-1:SHIFT];
                    end else if (r_phase == 2'd1) begin
                        r_rem <= seq_rem[SW-1:0];
                    end else begin
                        r_valid[r_rem] <= 1'b1;
                        r_addr  <= AW'(r_rem * PACKET_BYTES);
                        r_idx   <= '0;
                        r_pend  <= 1'b0;
                        r_state <= S_COPY;
                    end
                end
                S_COPY: begin
                    r_pend <= issue;
                    if (issue) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (r_pend) begin
                        r_addr <= r_addr + 1'b1;
                    end
                    if (!issue && !r_pend && r_idx == XW'(PACKET_BYTES)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_POP: begin
                    r_pend <= issue;
                    if (issue) begin
                        r_idx   <= r_idx + 1'b1;
                        r_addr  <= r_addr + 1'b1;
                        r_plast <= (r_idx == XW'(PACKET_BYTES - 1));
                    end
                    if (!issue && !r_pend && r_idx == XW'(PACKET_BYTES)) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* dv/jitter_scoreboard_pkg.sv */
`timescale 1ns / 1ps

package jitter_scoreboard_pkg;

    import sijb_pkg::*;

    class reorder_scoreboard;

        logic [7:0] staged [PACKET_BYTES_DEF];
        int         staged_len;
        logic [7:0] slot_bytes [SLOT_COUNT_DEF][PACKET_BYTES_DEF];
        bit         slot_full [SLOT_COUNT_DEF];
        int         cursor;
        t_result    due_results [$];
        int         errors;
        int         checked;
        int         commits;
        int         rejects;
        int         full_pops;
        int         empty_pops;

        function new();
            staged_len = 0;
            cursor     = SLOT_COUNT_DEF / 2;
            foreach (slot_full[s]) begin
                slot_full[s] = 1'b0;
            end
            errors     = 0;
            checked    = 0;
            commits    = 0;
            rejects    = 0;
            full_pops  = 0;
            empty_pops = 0;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // Works out what an accepted request will produce and queues it.
        function void note_request(logic op, logic [7:0] data, logic last);
            t_result r;
            int      slot;
            if (op == OP_PUSH) begin
                if (staged_len < PACKET_BYTES_DEF) begin
                    staged[staged_len] = data;
                    staged_len++;
                end else begin
                    staged_len = PACKET_BYTES_DEF + 1;
                end
                if (!last) begin
                    return;
                end
                r.data = 8'h00;
                r.last = 1'b1;
                if (staged_len == PACKET_BYTES_DEF) begin
                    slot = int'({staged[2], staged[3]}) % SLOT_COUNT_DEF;
                    slot_bytes[slot] = staged;
                    slot_full[slot]  = 1'b1;
                    r.status = ST_OK;
                    commits++;
                end else begin
                    r.status = ST_REJECT;
                    rejects++;
                end
                staged_len = 0;
                due_results.push_back(r);
            end else begin
                slot   = cursor;
                cursor = (cursor + 1) % SLOT_COUNT_DEF;
                if (!slot_full[slot]) begin
                    r.data   = 8'h00;
                    r.status = ST_NO_DATA;
                    r.last   = 1'b1;
                    due_results.push_back(r);
                    empty_pops++;
                end else begin
                    for (int n = 0; n < PACKET_BYTES_DEF; n++) begin
                        r.data   = slot_bytes[slot][n];
                        r.status = ST_OK;
                        r.last   = (n == PACKET_BYTES_DEF - 1);
                        due_results.push_back(r);
                    end
                    slot_full[slot] = 1'b0;
                    full_pops++;
                end
            end
        endfunction

        function void check_result(logic [7:0] data, logic [1:0] status, logic last);
            t_result want;
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got byte %h status %0d last %b",
                         $time, data, status, last);
                errors++;
                return;
            end
            want = due_results.pop_front();
            checked++;
            if (data !== want.data) begin
                $display("%0t: out_byte mismatch, expected %h, got %h", $time, want.data, data);
                errors++;
            end
            if (status !== want.status) begin
                $display("%0t: status mismatch, expected %0d, got %0d", $time, want.status,
                         status);
                errors++;
            end
            if (last !== want.last) begin
                $display("%0t: last_result mismatch, expected %b, got %b", $time, want.last,
                         last);
                errors++;
            end
        endfunction

    endclass

endpackage

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    import sijb_pkg::*;
    import jitter_scoreboard_pkg::*;

    localparam int PKT         = PACKET_BYTES_DEF;
    localparam int IDLE_LIMIT  = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int ITEMS       = 280;
    localparam int QUIET_ITEMS = 40;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_valid       = 1'b0;
    logic       i_opcode      = OP_PUSH;
    logic [7:0] i_data_byte   = 8'h00;
    logic       i_last_byte   = 1'b0;
    logic       i_stall       = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic [1:0] o_status;
    logic       o_last_result;

    reorder_scoreboard sb;
    bit quiet        = 1'b0;
    bit rx_hold_req  = 1'b0;
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int requests     = 0;
    int idle_cycles  = 0;

    sequence_indexed_jitter_buffer_unit #(
        .SLOT_COUNT   (SLOT_COUNT_DEF),
        .PACKET_BYTES (PACKET_BYTES_DEF)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_opcode      (i_opcode),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_status      (o_status),
        .o_last_result (o_last_result)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    task automatic send_request(logic op, logic [7:0] data, logic last);
        int gap;
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 99) < tx_idle_pct) begin
            gap = $urandom_range(1, 15);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_opcode    <= op;
        i_data_byte <= data;
        i_last_byte <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(op, data, last);
        requests++;
    endtask

    task automatic idle_input();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    // fill < 0 gives random payload bytes.
    task automatic push_packet(int len, logic [15:0] seq, int fill);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            b = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
            if (i == 2) begin
                b = seq[15:8];
            end else if (i == 3) begin
                b = seq[7:0];
            end
            send_request(OP_PUSH, b, i == len - 1);
        end
    endtask

    task automatic pop_packet();
        send_request(OP_POP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    task automatic wait_drained();
        idle_input();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin : receiver
        int burst;
        burst = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                rx_hold_req = 1'b0;
            end else if (burst > 0) begin
                i_stall <= 1'b1;
                burst--;
            end else if (!quiet && $urandom_range(0, 99) < rx_idle_pct) begin
                i_stall <= 1'b1;
                burst = $urandom_range(0, 14);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            sb.check_result(o_out_byte, o_status, o_last_result);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog expired, nothing moved for %0d cycles, %0d results pending",
                     $time, IDLE_LIMIT, sb.pending());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int kind;
        int len;
        int op;
        sb = new();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The cursor starts at the middle slot, which is empty after reset.
        pop_packet();
        push_packet(PKT, 16'h0009, 8'h00);
        pop_packet();
        push_packet(1, 16'h0000, -1);
        push_packet(3, 16'h0000, -1);
        push_packet(PKT + 3, 16'h000A, -1);
        push_packet(PKT, 16'hFFFF, 8'hFF);
        push_packet(PKT, 16'h7FEF, -1);
        wait_drained();

        // Block the output while pops pile up; the last one finds the overwritten slot.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_req = 1'b1;
        repeat (6) pop_packet();
        wait_drained();

        op = 0;
        while (requests < ITEMS) begin
            if (op % 4 == 0) begin
                tx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
                rx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
            end
            if (requests >= ITEMS - QUIET_ITEMS) begin
                quiet = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 25) begin
                push_packet(PKT, 16'($urandom_range(0, 65535)), -1);
            end else if (kind < 70) begin
                pop_packet();
            end else begin
                len = $urandom_range(1, 6);
                push_packet(len, 16'($urandom_range(0, 65535)), -1);
            end
            if (op % 6 == 5) begin
                wait_drained();
            end
            op++;
        end

        wait_drained();
        repeat (80) @(posedge i_clk);
        $display("Sent %0d requests: %0d packets stored, %0d rejected.",
                 requests, sb.commits, sb.rejects);
        $display("Popped %0d packets and %0d empty slots, checked %0d results, %0d errors.",
                 sb.full_pops, sb.empty_pops, sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
